>>> hdl/dpalu_pkg.sv
// Shared widths, opcode and shift codes, and status types of the data-processing ALU.
`default_nettype none

package dpalu_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int AMT_WIDTH   = 8;
   localparam int REG_WIDTH   = 4;
   localparam int FLAGS_WIDTH = 4;

   localparam logic [REG_WIDTH-1:0] PC_INDEX = 4'hF;

   typedef enum logic [3:0] {
      OP_AND = 4'h0,
      OP_EOR = 4'h1,
      OP_SUB = 4'h2,
      OP_RSB = 4'h3,
      OP_ADD = 4'h4,
      OP_ADC = 4'h5,
      OP_SBC = 4'h6,
      OP_RSC = 4'h7,
      OP_TST = 4'h8,
      OP_TEQ = 4'h9,
      OP_CMP = 4'hA,
      OP_CMN = 4'hB,
      OP_ORR = 4'hC,
      OP_MOV = 4'hD,
      OP_BIC = 4'hE,
      OP_MVN = 4'hF
   } opcode_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   // Carry, overflow and operation class from the ALU to the flag logic.
   typedef struct packed {
      logic carry;
      logic overflow;
      logic arith;
   } alu_status_type;

   // Packed N,Z,C,V with N in the top bit.
   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

endpackage

`default_nettype wire

>>> hdl/dpalu_channels.sv
// Valid/ready channel interfaces for the instruction beats and the result beats.
`default_nettype none

interface dpalu_req_if
   import dpalu_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   instruction;
   logic [DATA_WIDTH-1:0]   first_operand;
   logic [DATA_WIDTH-1:0]   shift_source;
   logic [AMT_WIDTH-1:0]    shift_amount_reg;

   modport source (output valid, instruction, first_operand, shift_source,
                   shift_amount_reg, input ready);
   modport sink   (input valid, instruction, first_operand, shift_source,
                   shift_amount_reg, output ready);
endinterface

interface dpalu_rsp_if
   import dpalu_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   result_value;
   logic                    write_enable;
   logic [REG_WIDTH-1:0]    dest_index;
   logic [FLAGS_WIDTH-1:0]  flags_out;
   logic                    status_restore;

   modport source (output valid, result_value, write_enable, dest_index, flags_out,
                   status_restore, input ready);
   modport sink   (input valid, result_value, write_enable, dest_index, flags_out,
                   status_restore, output ready);
endinterface

`default_nettype wire

>>> hdl/dataproc_alu_with_shifter_flags.sv
// Top level of the data-processing execute unit: operand register, shifter, ALU, flags.
//
// Executes one data-processing instruction per beat. A request beat carries the
// instruction word, Rn, Rm and the low byte of Rs; it is captured in an operand
// register, goes through the barrel shifter and the ALU combinationally, and lands in
// the result register together with the NZCV flags as they stand after that
// instruction. Throughput is one beat per cycle while the response side is ready. A
// request beat passes through the operand register and then the result register
// before response valid rises. The flag register is updated at the same edge the
// instruction moves into the result register, so the next instruction (ADC, SBC,
// RSC, RRX, carry-preserving shifts) always sees the flags of the one before it.
// Flags change only when Rd is not 15 and S is set or the opcode is a compare or
// test. With S set and Rd 15 on a writing opcode, status_restore is raised instead.
// Backpressure from the response side stalls both stages; req ready follows rsp
// ready combinationally. Flags reset to zero.
`default_nettype none

module dataproc_alu_with_shifter_flags
   import dpalu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dpalu_req_if.sink   req_bus,
   dpalu_rsp_if.source rsp_bus
);

   // Operand stage.
   logic                  op_valid_ff, op_valid_in;
   logic [DATA_WIDTH-1:0] op_instr_ff, op_instr_in;
   logic [DATA_WIDTH-1:0] op_rn_ff, op_rn_in;
   logic [DATA_WIDTH-1:0] op_rm_ff, op_rm_in;
   logic [AMT_WIDTH-1:0]  op_rs_ff, op_rs_in;

   // Result stage.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  rsp_result_ff, rsp_result_in;
   logic                   rsp_we_ff, rsp_we_in;
   logic [REG_WIDTH-1:0]   rsp_dest_ff, rsp_dest_in;
   flags_type              rsp_flags_ff, rsp_flags_in;
   logic                   rsp_restore_ff, rsp_restore_in;

   // Architectural flags.
   flags_type flags_ff, flags_in;

   logic                  rsp_free;
   logic                  advance;
   logic                  take_req;
   opcode_type            opcode;
   logic                  sbit;
   logic [REG_WIDTH-1:0]  rd;
   logic                  is_test;
   logic [DATA_WIDTH-1:0] shift_op;
   logic                  shift_carry;
   logic [DATA_WIDTH-1:0] alu_result;
   alu_status_type        alu_status;
   flags_type             next_flags;

   // Result register frees up when empty or when its beat is taken this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = op_valid_ff && rsp_free;
   assign req_bus.ready = !op_valid_ff || rsp_free;
   assign take_req = req_bus.valid && req_bus.ready;

   assign opcode = opcode_type'(op_instr_ff[24:21]);
   assign sbit   = op_instr_ff[20];
   assign rd     = op_instr_ff[15:12];

   always_comb begin
      is_test = 1'b0;
      case (opcode)
         OP_TST, OP_TEQ, OP_CMP, OP_CMN: is_test = 1'b1;
         default:                        is_test = 1'b0;
      endcase
   end

   dpalu_shifter u_shifter (
      .instruction      (op_instr_ff),
      .shift_source     (op_rm_ff),
      .shift_amount_reg (op_rs_ff),
      .carry_in         (flags_ff.c),
      .operand          (shift_op),
      .carry_out        (shift_carry)
   );

   dpalu_alu u_alu (
      .opcode        (opcode),
      .first_operand (op_rn_ff),
      .operand       (shift_op),
      .carry_in      (flags_ff.c),
      .result        (alu_result),
      .status        (alu_status)
   );

   // Flag update: logical ops take C from the shifter and hold V.
   always_comb begin
      next_flags = flags_ff;
      if ((sbit || is_test) && rd != PC_INDEX) begin
         next_flags.n = alu_result[DATA_WIDTH-1];
         next_flags.z = (alu_result == '0);
         if (alu_status.arith) begin
            next_flags.c = alu_status.carry;
            next_flags.v = alu_status.overflow;
         end else begin
            next_flags.c = shift_carry;
         end
      end
   end

   always_comb begin
      // Capture a new beat whenever the operand stage is empty or moving on.
      op_valid_in = take_req ? 1'b1 : (advance ? 1'b0 : op_valid_ff);
      op_instr_in = take_req ? req_bus.instruction      : op_instr_ff;
      op_rn_in    = take_req ? req_bus.first_operand    : op_rn_ff;
      op_rm_in    = take_req ? req_bus.shift_source     : op_rm_ff;
      op_rs_in    = take_req ? req_bus.shift_amount_reg : op_rs_ff;

      // Hold the result beat until taken; load when the operand stage advances.
      rsp_valid_in   = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_result_in  = advance ? alu_result : rsp_result_ff;
      rsp_we_in      = advance ? !is_test   : rsp_we_ff;
      rsp_dest_in    = advance ? rd         : rsp_dest_ff;
      rsp_flags_in   = advance ? next_flags : rsp_flags_ff;
      rsp_restore_in = advance ? (sbit && rd == PC_INDEX && !is_test) : rsp_restore_ff;

      flags_in = advance ? next_flags : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      op_instr_ff    <= op_instr_in;
      op_rn_ff       <= op_rn_in;
      op_rm_ff       <= op_rm_in;
      op_rs_ff       <= op_rs_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_we_ff      <= rsp_we_in;
      rsp_dest_ff    <= rsp_dest_in;
      rsp_flags_ff   <= rsp_flags_in;
      rsp_restore_ff <= rsp_restore_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_value   = rsp_result_ff;
   assign rsp_bus.write_enable   = rsp_we_ff;
   assign rsp_bus.dest_index     = rsp_dest_ff;
   assign rsp_bus.flags_out      = rsp_flags_ff;
   assign rsp_bus.status_restore = rsp_restore_ff;

endmodule

`default_nettype wire

>>> hdl/dpalu_shifter.sv
// Barrel shifter: rotated immediate, or Rm shifted by immediate or register amount.
`default_nettype none

module dpalu_shifter
   import dpalu_pkg::*;
(
   input  wire logic [DATA_WIDTH-1:0] instruction,
   input  wire logic [DATA_WIDTH-1:0] shift_source,
   input  wire logic [AMT_WIDTH-1:0]  shift_amount_reg,
   input  wire logic                  carry_in,
   output logic      [DATA_WIDTH-1:0] operand,
   output logic                       carry_out
);

   function automatic logic [DATA_WIDTH-1:0] rotr(input logic [DATA_WIDTH-1:0] v,
                                                  input logic [4:0] n);
      logic [2*DATA_WIDTH-1:0] d;
      d = {v, v} >> n;
      return d[DATA_WIDTH-1:0];
   endfunction

   logic [4:0]            amt5;
   logic [DATA_WIDTH:0]   lsl_w;
   logic [DATA_WIDTH:0]   lsr_w;
   logic [DATA_WIDTH:0]   asr_w;
   logic [DATA_WIDTH-1:0] ror_res;
   logic [DATA_WIDTH-1:0] imm_res;
   logic [4:0]            imm_rot;
   logic                  reg_big;
   logic                  reg_eq32;
   logic                  msb;
   shift_kind_type        kind;

   assign kind = shift_kind_type'(instruction[6:5]);
   assign amt5 = instruction[4] ? shift_amount_reg[4:0] : instruction[11:7];
   assign msb  = shift_source[DATA_WIDTH-1];

   // Extra bit below or above the word catches the last bit shifted out.
   assign lsl_w   = {1'b0, shift_source} << amt5;
   assign lsr_w   = {shift_source, 1'b0} >> amt5;
   assign asr_w   = $unsigned($signed({shift_source, 1'b0}) >>> amt5);
   assign ror_res = rotr(shift_source, amt5);

   assign imm_rot = {instruction[11:8], 1'b0};
   assign imm_res = rotr({24'd0, instruction[7:0]}, imm_rot);

   assign reg_big  = |shift_amount_reg[7:5];
   assign reg_eq32 = (shift_amount_reg == 8'd32);

   always_comb begin
      operand   = shift_source;
      carry_out = carry_in;
      if (instruction[25]) begin
         operand = imm_res;
         if (imm_rot != 5'd0) begin
            carry_out = imm_res[DATA_WIDTH-1];
         end
      end else if (instruction[4]) begin
         if (shift_amount_reg != 8'd0) begin
            case (kind)
               SH_LSL: begin
                  if (!reg_big) begin
                     operand   = lsl_w[DATA_WIDTH-1:0];
                     carry_out = lsl_w[DATA_WIDTH];
                  end else begin
                     operand   = '0;
                     carry_out = reg_eq32 & shift_source[0];
                  end
               end
               SH_LSR: begin
                  if (!reg_big) begin
                     operand   = lsr_w[DATA_WIDTH:1];
                     carry_out = lsr_w[0];
                  end else begin
                     operand   = '0;
                     carry_out = reg_eq32 & msb;
                  end
               end
               SH_ASR: begin
                  if (!reg_big) begin
                     operand   = asr_w[DATA_WIDTH:1];
                     carry_out = asr_w[0];
                  end else begin
                     operand   = {DATA_WIDTH{msb}};
                     carry_out = msb;
                  end
               end
               SH_ROR: begin
                  operand   = ror_res;
                  carry_out = ror_res[DATA_WIDTH-1];
               end
               default: begin
                  operand   = shift_source;
                  carry_out = carry_in;
               end
            endcase
         end
      end else begin
         case (kind)
            SH_LSL: begin
               if (amt5 != 5'd0) begin
                  operand   = lsl_w[DATA_WIDTH-1:0];
                  carry_out = lsl_w[DATA_WIDTH];
               end
            end
            SH_LSR: begin
               if (amt5 == 5'd0) begin
                  operand   = '0;
                  carry_out = msb;
               end else begin
                  operand   = lsr_w[DATA_WIDTH:1];
                  carry_out = lsr_w[0];
               end
            end
            SH_ASR: begin
               if (amt5 == 5'd0) begin
                  operand   = {DATA_WIDTH{msb}};
                  carry_out = msb;
               end else begin
                  operand   = asr_w[DATA_WIDTH:1];
                  carry_out = asr_w[0];
               end
            end
            SH_ROR: begin
               // Zero amount is RRX: shift the old carry in at the top.
               if (amt5 == 5'd0) begin
                  operand   = {carry_in, shift_source[DATA_WIDTH-1:1]};
                  carry_out = shift_source[0];
               end else begin
                  operand   = ror_res;
                  carry_out = ror_res[DATA_WIDTH-1];
               end
            end
            default: begin
               operand   = shift_source;
               carry_out = carry_in;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hdl/dpalu_alu.sv
// Sixteen-opcode ALU with one shared 33-bit adder.
`default_nettype none

module dpalu_alu
   import dpalu_pkg::*;
(
   input  wire opcode_type            opcode,
   input  wire logic [DATA_WIDTH-1:0] first_operand,
   input  wire logic [DATA_WIDTH-1:0] operand,
   input  wire logic                  carry_in,
   output logic      [DATA_WIDTH-1:0] result,
   output alu_status_type             status
);

   logic [DATA_WIDTH-1:0] add_a;
   logic [DATA_WIDTH-1:0] add_b;
   logic                  add_c;
   logic [DATA_WIDTH:0]   sum;

   // Steer operands: subtracts invert the subtrahend and add the carry.
   always_comb begin
      add_a = first_operand;
      add_b = operand;
      add_c = 1'b0;
      case (opcode)
         OP_SUB, OP_CMP: begin
            add_b = ~operand;
            add_c = 1'b1;
         end
         OP_RSB: begin
            add_a = operand;
            add_b = ~first_operand;
            add_c = 1'b1;
         end
         OP_ADC: begin
            add_c = carry_in;
         end
         OP_SBC: begin
            add_b = ~operand;
            add_c = carry_in;
         end
         OP_RSC: begin
            add_a = operand;
            add_b = ~first_operand;
            add_c = carry_in;
         end
         default: begin
            add_c = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_WIDTH{1'b0}}, add_c};

   always_comb begin
      status.carry    = sum[DATA_WIDTH];
      status.overflow = ~(add_a[DATA_WIDTH-1] ^ add_b[DATA_WIDTH-1])
                        & (add_a[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1]);
      status.arith    = 1'b0;
      result          = sum[DATA_WIDTH-1:0];
      case (opcode)
         OP_AND, OP_TST: result = first_operand & operand;
         OP_EOR, OP_TEQ: result = first_operand ^ operand;
         OP_ORR:         result = first_operand | operand;
         OP_MOV:         result = operand;
         OP_BIC:         result = first_operand & ~operand;
         OP_MVN:         result = ~operand;
         default:        status.arith = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

>>> bench/dataproc_alu_with_shifter_flags_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the data-processing ALU: directed and random instruction beats.

module dataproc_alu_with_shifter_flags_test;
   import dpalu_pkg::*;

   // One response beat as the predictor expects it.
   typedef struct packed {
      logic [DATA_WIDTH-1:0]  result_value;
      logic                   write_enable;
      logic [REG_WIDTH-1:0]   dest_index;
      flags_type              flags_out;
      logic                   status_restore;
   } dp_result_type;

   logic clock;
   logic reset;

   dpalu_req_if req_ch ();
   dpalu_rsp_if rsp_ch ();

   dataproc_alu_with_shifter_flags uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // Predictor state: NZCV as they stand after the last accepted instruction.
   flags_type      arch_flags = '0;
   // Results owed by the block, oldest first.
   dp_result_type  pending_results[$];
   int unsigned    error_count = 0;
   // Random idle bursts on the request side and stall bursts on the response side.
   bit             send_idling = 1'b1;
   bit             sink_stalling = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   function automatic logic [31:0] rotate_right(input logic [31:0] value,
                                                input logic [4:0] amount);
      logic [63:0] doubled;
      doubled = {value, value} >> amount;
      return doubled[31:0];
   endfunction

   // Second operand and shifter carry. carry_in is the C flag from before the instruction.
   function automatic logic [31:0] shifter_operand(input logic [31:0] instr,
                                                   input logic [31:0] rm,
                                                   input logic [7:0] rs,
                                                   input logic carry_in,
                                                   output logic carry_out);
      shift_kind_type kind;
      logic [4:0]     imm_amount;
      logic [7:0]     distance;
      logic [63:0]    wide;
      logic [31:0]    shifted;
      kind       = shift_kind_type'(instr[6:5]);
      imm_amount = instr[11:7];
      carry_out  = carry_in;
      if (instr[25]) begin
         // rotated immediate; a zero rotate keeps the old carry
         shifted = rotate_right({24'd0, instr[7:0]}, {instr[11:8], 1'b0});
         if (instr[11:8] != 4'd0) carry_out = shifted[31];
         return shifted;
      end
      if (instr[4]) begin
         distance = rs;
      end else if (imm_amount == 5'd0 && kind != SH_LSL) begin
         // immediate 0: ROR means RRX, LSR and ASR mean a shift by 32
         if (kind == SH_ROR) begin
            carry_out = rm[0];
            return {carry_in, rm[31:1]};
         end
         distance = 8'd32;
      end else begin
         distance = {3'd0, imm_amount};
      end
      // LSL #0 and any register amount of 0 pass Rm and the carry through
      if (distance == 8'd0) return rm;
      case (kind)
         SH_LSL: begin
            wide      = {32'd0, rm} << distance;
            carry_out = wide[32];
            shifted   = wide[31:0];
         end
         SH_LSR: begin
            wide      = {rm, 32'd0} >> distance;
            carry_out = wide[31];
            shifted   = wide[63:32];
         end
         SH_ASR: begin
            if (distance >= 8'd32) begin
               carry_out = rm[31];
               shifted   = {32{rm[31]}};
            end else begin
               carry_out = rm[distance[4:0] - 5'd1];
               shifted   = $signed(rm) >>> distance;
            end
         end
         default: begin
            // a nonzero multiple of 32 leaves Rm as it is, carry from bit 31
            shifted   = rotate_right(rm, distance[4:0]);
            carry_out = shifted[31];
         end
      endcase
      return shifted;
   endfunction

   // Execute one instruction against arch_flags and advance them.
   function automatic dp_result_type execute_dp(input logic [31:0] instr,
                                                input logic [31:0] rn,
                                                input logic [31:0] rm,
                                                input logic [7:0] rs);
      opcode_type     op;
      logic [31:0]    op2;
      logic [31:0]    lhs;
      logic [31:0]    rhs;
      logic [31:0]    value;
      logic           add_cin;
      logic           shift_carry;
      logic           carry;
      logic           overflow;
      logic           is_arith;
      logic           is_test;
      logic           sbit;
      logic [3:0]     rd;
      dp_result_type  beat;
      op       = opcode_type'(instr[24:21]);
      sbit     = instr[20];
      rd       = instr[15:12];
      is_test  = (op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
      op2      = shifter_operand(instr, rm, rs, arch_flags.c, shift_carry);
      is_arith = 1'b1;
      lhs      = rn;
      rhs      = op2;
      add_cin  = 1'b0;
      value    = '0;
      carry    = 1'b0;
      overflow = 1'b0;
      case (op)
         OP_AND, OP_TST: begin value = rn & op2;  is_arith = 1'b0; end
         OP_EOR, OP_TEQ: begin value = rn ^ op2;  is_arith = 1'b0; end
         OP_SUB, OP_CMP: begin rhs = ~op2; add_cin = 1'b1; end
         OP_RSB:         begin lhs = op2; rhs = ~rn; add_cin = 1'b1; end
         OP_ADD, OP_CMN: add_cin = 1'b0;
         OP_ADC:         add_cin = arch_flags.c;
         OP_SBC:         begin rhs = ~op2; add_cin = arch_flags.c; end
         OP_RSC:         begin lhs = op2; rhs = ~rn; add_cin = arch_flags.c; end
         OP_ORR:         begin value = rn | op2;  is_arith = 1'b0; end
         OP_MOV:         begin value = op2;       is_arith = 1'b0; end
         OP_BIC:         begin value = rn & ~op2; is_arith = 1'b0; end
         default:        begin value = ~op2;      is_arith = 1'b0; end
      endcase
      if (is_arith) begin
         {carry, value} = {1'b0, lhs} + {1'b0, rhs} + {32'd0, add_cin};
         overflow       = (lhs[31] == rhs[31]) && (value[31] != lhs[31]);
      end
      // Rd of 15 never touches the flags; tests update them whatever S says
      if ((sbit || is_test) && rd != PC_INDEX) begin
         arch_flags.n = value[31];
         arch_flags.z = (value == 32'd0);
         if (is_arith) begin
            arch_flags.c = carry;
            arch_flags.v = overflow;
         end else begin
            arch_flags.c = shift_carry;
         end
      end
      beat.result_value   = value;
      beat.write_enable   = !is_test;
      beat.dest_index     = rd;
      beat.flags_out      = arch_flags;
      beat.status_restore = sbit && rd == PC_INDEX && !is_test;
      return beat;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Instruction encoding and operand pickers
   // ---------------------------------------------------------------------------------------

   // Condition and the Rn index do not matter to the block; keep them random, bits 27:26 cleared.
   function automatic logic [31:0] dp_word(input opcode_type op, input logic s,
                                           input logic [3:0] rd, input logic [12:0] operand2);
      logic [31:0] word;
      word        = $urandom();
      word[27:26] = 2'b00;
      word[25]    = operand2[12];
      word[24:21] = op;
      word[20]    = s;
      word[15:12] = rd;
      word[11:0]  = operand2[11:0];
      return word;
   endfunction

   function automatic logic [12:0] imm_operand(input logic [3:0] rot, input logic [7:0] imm8);
      return {1'b1, rot, imm8};
   endfunction

   function automatic logic [12:0] imm_shift(input shift_kind_type kind,
                                             input logic [4:0] amount);
      logic [3:0] rm_index;
      rm_index = $urandom();
      return {1'b0, amount, kind, 1'b0, rm_index};
   endfunction

   // Register-specified shift; bit 7 is ignored by the block, so it is left random.
   function automatic logic [12:0] reg_shift(input shift_kind_type kind);
      logic [3:0] rs_index;
      logic [3:0] rm_index;
      logic       spare;
      rs_index = $urandom();
      rm_index = $urandom();
      spare    = $urandom();
      return {1'b0, rs_index, spare, kind, 1'b1, rm_index};
   endfunction

   // Register values biased toward the carry and overflow corners.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   // Rs low byte: zero, in range, exactly 32, multiples of 32, and beyond.
   function automatic logic [7:0] pick_amount();
      logic [7:0] amount;
      case ($urandom_range(0, 5))
         0:       amount = 8'd0;
         1:       amount = 8'd32;
         2:       amount = 8'd32 * $urandom_range(2, 7);
         3:       amount = $urandom_range(1, 31);
         4:       amount = $urandom_range(33, 255);
         default: amount = $urandom();
      endcase
      return amount;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Present one instruction beat. Enter and leave at a falling edge.
   task automatic send_dp(input logic [31:0] instr, input logic [31:0] rn,
                          input logic [31:0] rm, input logic [7:0] rs);
      if (send_idling && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.instruction      <= instr;
      req_ch.first_operand    <= rn;
      req_ch.shift_source     <= rm;
      req_ch.shift_amount_reg <= rs;
      do @(posedge clock); while (!req_ch.ready);
      // accepted at this edge: predict in acceptance order
      pending_results.push_back(execute_dp(instr, rn, rm, rs));
      @(negedge clock);
   endtask

   // Hold off the request side until every owed result has come back.
   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random opcode, S bit and Rd with an operand of any shape.
   task automatic send_shaped_dp();
      opcode_type  op;
      logic [12:0] operand2;
      logic [4:0]  amount;
      op = opcode_type'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0: operand2 = imm_operand($urandom(), $urandom());
         1: begin
            case ($urandom_range(0, 3))
               0:       amount = 5'd0;
               1:       amount = 5'd1;
               2:       amount = 5'd31;
               default: amount = $urandom();
            endcase
            operand2 = imm_shift(shift_kind_type'($urandom_range(0, 3)), amount);
         end
         default: operand2 = reg_shift(shift_kind_type'($urandom_range(0, 3)));
      endcase
      send_dp(dp_word(op, $urandom_range(0, 1), $urandom_range(0, 15), operand2),
              pick_word(), pick_word(), pick_amount());
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------------

   // Stall in random bursts with long open stretches between.
   initial begin : drive_rsp_ready
      int unsigned hold;
      hold         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0 && sink_stalling && !reset && $urandom_range(0, 9) == 0)
            hold = $urandom_range(1, 17);
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Compare every accepted result beat against the oldest prediction.
   always @(posedge clock) begin : check_results
      dp_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing owed, expected none, actual %h",
                     $time, rsp_ch.result_value);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_value", want.result_value, rsp_ch.result_value);
            check_field("write_enable", want.write_enable, rsp_ch.write_enable);
            check_field("dest_index", want.dest_index, rsp_ch.dest_index);
            check_field("flags_out", want.flags_out, rsp_ch.flags_out);
            check_field("status_restore", want.status_restore, rsp_ch.status_restore);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Every opcode once, each carrying a shifter corner, then Rd=15, flag corners and word extremes.
   task automatic test_directed_ops();
      // all ones through LSL #0: carry stays as reset left it
      send_dp(dp_word(OP_AND, 1'b1, 4'd1, imm_shift(SH_LSL, 5'd0)),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      // LSR #0 means a shift by 32
      send_dp(dp_word(OP_EOR, 1'b1, 4'd2, imm_shift(SH_LSR, 5'd0)),
              32'h0, 32'h8000_0000, 8'h00);
      // ASR #0 fills with the sign
      send_dp(dp_word(OP_SUB, 1'b1, 4'd3, imm_shift(SH_ASR, 5'd0)),
              32'h0, 32'h8000_0000, 8'h00);
      // ROR #0 is RRX and pulls in the old carry
      send_dp(dp_word(OP_RSB, 1'b1, 4'd4, imm_shift(SH_ROR, 5'd0)),
              32'h5, 32'h1, 8'h00);
      // zero rotate immediate, 33-bit carry out of the add
      send_dp(dp_word(OP_ADD, 1'b1, 4'd5, imm_operand(4'd0, 8'hFF)),
              32'hFFFF_FFFF, $urandom(), 8'h00);
      // widest rotate, ADC eats the carry just set
      send_dp(dp_word(OP_ADC, 1'b1, 4'd6, imm_operand(4'hF, 8'hFF)),
              32'h0, $urandom(), 8'h00);
      // register LSL by exactly 32 and by 33
      send_dp(dp_word(OP_SBC, 1'b1, 4'd7, reg_shift(SH_LSL)), 32'h1, 32'h1, 8'd32);
      send_dp(dp_word(OP_RSC, 1'b1, 4'd8, reg_shift(SH_LSL)),
              32'h0, 32'hFFFF_FFFF, 8'd33);
      // tests set flags with S clear; register LSR by 32 and by more
      send_dp(dp_word(OP_TST, 1'b0, 4'd9, reg_shift(SH_LSR)),
              32'hFFFF_FFFF, 32'h8000_0000, 8'd32);
      send_dp(dp_word(OP_TEQ, 1'b0, 4'd10, reg_shift(SH_LSR)),
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd40);
      // register ASR far past 32
      send_dp(dp_word(OP_CMP, 1'b1, 4'd11, reg_shift(SH_ASR)),
              32'h7FFF_FFFF, 32'h8000_0000, 8'd200);
      // register ROR by a multiple of 32, signed overflow on the add
      send_dp(dp_word(OP_CMN, 1'b1, 4'd12, reg_shift(SH_ROR)),
              32'h8000_0000, 32'h8000_0000, 8'd64);
      // register amount 0 keeps Rm and the carry
      send_dp(dp_word(OP_ORR, 1'b1, 4'd13, reg_shift(SH_ROR)),
              32'h0, 32'h1234_5678, 8'd0);
      // bit 7 set with bit 4 set still decodes as a register shift
      send_dp(dp_word(OP_MOV, 1'b1, 4'd14, reg_shift(SH_LSL)) | 32'h0000_0080,
              32'h0, 32'hFFFF_FFFF, 8'd255);
      send_dp(dp_word(OP_BIC, 1'b1, 4'd0, reg_shift(SH_ROR)),
              32'hFFFF_FFFF, 32'h0000_00F1, 8'd36);
      send_dp(dp_word(OP_MVN, 1'b0, 4'd1, imm_shift(SH_LSL, 5'd31)), 32'h0, 32'h0, 8'h00);
      // Rd=15: status restore on a writing opcode, no flag change on a compare
      send_dp(dp_word(OP_MOV, 1'b1, PC_INDEX, imm_operand(4'd0, 8'h00)),
              32'h0, 32'h0, 8'h00);
      send_dp(dp_word(OP_CMP, 1'b1, PC_INDEX, imm_operand(4'd0, 8'h01)),
              32'h0, 32'h0, 8'h00);
      // positive overflow, then a zero result with carry set
      send_dp(dp_word(OP_ADD, 1'b1, 4'd2, imm_operand(4'd0, 8'h01)),
              32'h7FFF_FFFF, 32'h0, 8'h00);
      send_dp(dp_word(OP_SUB, 1'b1, 4'd3, imm_operand(4'd0, 8'h00)), 32'h0, 32'h0, 8'h00);
      send_dp(dp_word(OP_ADC, 1'b0, 4'd4, imm_operand(4'd0, 8'h00)),
              32'hFFFF_FFFF, 32'h0, 8'h00);
      // whole-word extremes
      send_dp(32'h0000_0000, 32'h0, 32'h0, 8'h00);
      send_dp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
   endtask

   // Arbitrary instruction words: every bit of every field toggles.
   task automatic test_random_words();
      repeat (350) send_dp($urandom(), pick_word(), pick_word(), pick_amount());
   endtask

   // Structured words that aim at the shifter amount corners.
   task automatic test_shifter_edges();
      repeat (300) send_shaped_dp();
   endtask

   // A flag producer followed by carry consumers, with one full drain midway.
   task automatic test_carry_chains();
      opcode_type  op;
      logic [12:0] operand2;
      int          chain;
      for (chain = 0; chain < 80; chain++) begin
         if (chain == 40) wait_results_drained();
         case ($urandom_range(0, 4))
            0:       op = OP_CMP;
            1:       op = OP_CMN;
            2:       op = OP_ADD;
            3:       op = OP_SUB;
            default: op = OP_MOV;
         endcase
         operand2 = (op == OP_MOV) ? imm_shift(SH_LSR, $urandom())
                                   : reg_shift(shift_kind_type'($urandom_range(0, 3)));
         send_dp(dp_word(op, 1'b1, $urandom_range(0, 14), operand2),
                 pick_word(), pick_word(), pick_amount());
         repeat ($urandom_range(2, 4)) begin
            case ($urandom_range(0, 3))
               0:       op = OP_ADC;
               1:       op = OP_SBC;
               2:       op = OP_RSC;
               default: op = OP_MOV;
            endcase
            if (op == OP_MOV)
               operand2 = imm_shift(SH_ROR, 5'd0);
            else if ($urandom_range(0, 1) == 0)
               operand2 = imm_operand($urandom(), $urandom());
            else
               operand2 = reg_shift(shift_kind_type'($urandom_range(0, 3)));
            send_dp(dp_word(op, $urandom_range(0, 1), $urandom_range(0, 14), operand2),
                    pick_word(), pick_word(), pick_amount());
         end
      end
   endtask

   // Back-to-back beats with both sides open.
   task automatic test_steady_stream();
      send_idling   = 1'b0;
      sink_stalling = 1'b0;
      repeat (150) send_shaped_dp();
   endtask

   initial begin : run_tests
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.instruction      = '0;
      req_ch.first_operand    = '0;
      req_ch.shift_source     = '0;
      req_ch.shift_amount_reg = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_ops();
      test_random_words();
      test_shifter_edges();
      test_carry_chains();
      test_steady_stream();

      // drain, then let the two-stage pipe settle so strays get caught
      wait_results_drained();
      repeat (6) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
